/* sv/mers_pkg.sv */
`default_nettype none

package mers_pkg;

  // Request codes carried on the input channel.
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_INIT = 2'd1,
    REQ_STEP = 2'd2
  } req_t;

  // Default network shape.
  localparam int unsigned HIDDEN_UNITS_DEF = 8;
  localparam int unsigned TANH_DEPTH_DEF   = 256;

  // Fixed field widths.
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TANH_W = 18;
  localparam int unsigned ERR_W  = 31;

  // Accumulator width: 48-bit shifted products plus headroom for up to 17 terms.
  localparam int unsigned ACC_W = 56;

  // Idle cycles between the hidden layer and the output layer, so that the last
  // hidden activation is written before the output neuron reads it.
  localparam int unsigned ISSUE_GAP = 4;

  // 1.0 in Q16.16.
  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sd65536;

  // 1.0 in Q40.24, used while building the tanh table.
  localparam logic [63:0] E_ONE = 64'd16777216;

  // Shift-subtract division, evaluated only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh of a magnitude in Q16.16 (0 to 4.0): series for e^(2x/16), squared four times.
  function automatic logic [TANH_W-1:0] tanh_pos(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] q;
    int k;
    r    = ((x << 1) << 8) >> 4;
    term = E_ONE;
    sum  = E_ONE;
    for (k = 1; k <= 14; k++) begin
      term = udiv64((term * r) >> 24, 64'(k));
      sum  = sum + term;
    end
    e = sum;
    for (k = 0; k < 4; k++) begin
      e = (e * e) >> 24;
    end
    q = udiv64((e - E_ONE) << 16, e + E_ONE);
    return q[TANH_W-1:0];
  endfunction

  // Table entry k of a depth-entry table over [-4, 4).
  function automatic logic signed [TANH_W-1:0] tanh_entry(input int unsigned k,
                                                          input int unsigned depth);
    logic [63:0] off;
    logic [TANH_W-1:0] mag;
    off = udiv64(64'(k) * 64'd524288, 64'(depth));
    if (off < 64'd262144) begin
      mag = tanh_pos(64'd262144 - off);
      return -$signed(mag);
    end else begin
      mag = tanh_pos(off - 64'd262144);
      return $signed(mag);
    end
  endfunction

endpackage

`default_nettype wire

/* sv/mers_ram.sv */
`default_nettype none

module mers_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 41,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/mlp_euler_response_step_unit.sv */
`default_nettype none

// Neural-network driven oscillator step unit.
// Input channel (in_valid / in_stall): each request is a weight load, a state
// init or one time step, selected by in_req_type. Only a step request gives a
// result on the output channel (out_valid / out_stall).
// A load or init request leaves in_stall low, so the next request can be taken
// in the following cycle. A step request holds in_stall high until its result
// is loaded into the output register.
// The step runs on the single 32x32 multiplier, which serves one weight per
// cycle from the weight memory, apart from a gap before the output neuron, and
// then the two Euler products. out_valid rises when the result is loaded and
// the result is held in that register until taken. While the receiver stalls,
// new requests are still accepted; a step that finishes while the previous
// result is still waiting holds until that result is taken.
// Synchronous reset clears velocity, displacement, force, the error total and
// all control state. Weights are undefined until loaded.

module mlp_euler_response_step_unit #(
  parameter int unsigned HIDDEN_UNITS     = mers_pkg::HIDDEN_UNITS_DEF,
  parameter int unsigned TANH_TABLE_DEPTH = mers_pkg::TANH_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  in_req_type,
  input  wire logic        [5:0]  in_weight_index,
  input  wire logic signed [31:0] in_weight_value,
  input  wire logic signed [31:0] in_init_velocity,
  input  wire logic signed [31:0] in_init_displacement,
  input  wire logic signed [31:0] in_init_force,
  input  wire logic signed [31:0] in_time_delta,
  input  wire logic signed [31:0] in_target_value,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [17:0] out_net_output,
  output logic signed      [31:0] out_new_velocity,
  output logic signed      [31:0] out_new_displacement,
  output logic             [30:0] out_step_error,
  output logic             [30:0] out_error_total
);

  localparam int unsigned AW      = mers_pkg::ACC_W;
  localparam int unsigned TW      = mers_pkg::TANH_W;
  localparam int unsigned WCOUNT  = 5 * HIDDEN_UNITS + 1;
  localparam int unsigned OP_W    = $clog2(WCOUNT);
  localparam int unsigned HID_W   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int unsigned HCNT_W  = $clog2(HIDDEN_UNITS + 1);
  localparam int unsigned TIDX_W  = $clog2(TANH_TABLE_DEPTH);
  localparam int unsigned SCALE_W = 19 + $clog2(TANH_TABLE_DEPTH + 1);
  localparam int unsigned CMP_W   = (OP_W > 6) ? OP_W : 6;
  localparam int unsigned GAP_W   = $clog2(mers_pkg::ISSUE_GAP + 1);

  localparam logic [OP_W-1:0]     OP_OUT0     = OP_W'(4 * HIDDEN_UNITS);
  localparam logic [OP_W-1:0]     OP_LAST_HID = OP_W'(4 * HIDDEN_UNITS - 1);
  localparam logic [OP_W-1:0]     OP_BIAS     = OP_W'(5 * HIDDEN_UNITS);
  localparam logic [HCNT_W-1:0]   HCNT_OUT    = HCNT_W'(HIDDEN_UNITS);
  localparam logic [GAP_W-1:0]    GAP_LOAD    = GAP_W'(mers_pkg::ISSUE_GAP);
  localparam logic signed [AW-1:0] SPAN_POS   = AW'(262144);
  localparam logic signed [AW-1:0] SPAN_NEG   = -SPAN_POS;
  localparam logic signed [TW-1:0] TANH_POS1  = TW'(65536);
  localparam logic signed [TW-1:0] TANH_NEG1  = -TANH_POS1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_EMUL_O,
    ST_EADD_V,
    ST_EMUL_V,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    TS_TABLE,
    TS_POS,
    TS_NEG
  } tsel_t;

  // Control that travels with one multiply-accumulate through the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_tag_t;

  // Saturate a 49-bit sum to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -49'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  // Tanh table, built at elaboration.
  logic signed [TW-1:0] tanh_rom [TANH_TABLE_DEPTH];

  for (genvar g = 0; g < TANH_TABLE_DEPTH; g++) begin : g_rom
    localparam logic signed [TW-1:0] ENTRY = mers_pkg::tanh_entry(g, TANH_TABLE_DEPTH);
    assign tanh_rom[g] = ENTRY;
  end

  // Control state.
  state_t              state_r;
  logic [OP_W-1:0]     op_r;
  logic [GAP_W-1:0]    gap_r;
  logic [HCNT_W-1:0]   hcnt_r;
  mac_tag_t            tag_b_r;
  mac_tag_t            tag_c_r;
  logic                d_valid_r;
  logic                e_valid_r;
  logic                out_valid_r;

  // Architectural state.
  logic signed [31:0]  vel_r;
  logic signed [31:0]  disp_r;
  logic signed [31:0]  force_r;
  logic [30:0]         err_sum_r;

  // Datapath registers.
  logic signed [31:0]  dt_r;
  logic signed [31:0]  target_r;
  logic signed [31:0]  feed_b_r;
  logic signed [63:0]  prod_r;
  logic signed [AW-1:0] acc_r;
  logic [TIDX_W-1:0]   tidx_r;
  tsel_t               tsel_r;
  logic signed [TW-1:0] hid_r [HIDDEN_UNITS];
  logic signed [TW-1:0] o_r;
  logic signed [17:0]  out_net_r;
  logic signed [31:0]  out_vel_r;
  logic signed [31:0]  out_disp_r;
  logic [30:0]         out_err_r;
  logic [30:0]         out_total_r;

  logic                in_acc;
  logic                issue_en;
  logic                is_hid;
  logic                op_first;
  logic                op_last;
  logic signed [31:0]  op_feed;
  logic [OP_W-1:0]     hid_off;
  logic                wr_en;
  logic [OP_W-1:0]     wr_addr;
  logic [31:0]         rd_data;
  logic                prod_en;
  logic signed [31:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [63:0]  prod_sh;
  logic signed [47:0]  term48;
  logic signed [AW-1:0] acc_nxt;
  logic [18:0]         t_off;
  logic [SCALE_W-1:0]  t_scaled;
  tsel_t               tsel_nxt;
  logic signed [TW-1:0] tanh_val;
  logic signed [31:0]  vel_nxt;
  logic signed [31:0]  disp_nxt;
  logic signed [32:0]  diff;
  logic [32:0]         diff_abs;
  logic [30:0]         step_err;
  logic [31:0]         total_sum;
  logic [30:0]         total_nxt;
  logic                out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Weight loads write the memory directly; out-of-range indexes are dropped.
  assign wr_en   = in_acc && (in_req_type == mers_pkg::REQ_LOAD) &&
                   (CMP_W'(in_weight_index) < CMP_W'(WCOUNT));
  assign wr_addr = OP_W'(in_weight_index);

  mers_ram #(
    .WIDTH (32),
    .DEPTH (WCOUNT),
    .ADDR_W(OP_W)
  ) u_weights (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_weight_value),
    .rd_addr(op_r),
    .rd_data(rd_data)
  );

  // Issue: the op counter is the weight address. Hidden neuron h uses ops
  // 4h..4h+3 (velocity, displacement, force, bias); the output neuron follows.
  assign issue_en = (state_r == ST_ISSUE) && (gap_r == '0);
  assign is_hid   = (op_r < OP_OUT0);
  assign hid_off  = op_r - OP_OUT0;

  always_comb begin
    if (is_hid) begin
      op_first = (op_r[1:0] == 2'd0);
      op_last  = (op_r[1:0] == 2'd3);
      unique case (op_r[1:0])
        2'd0:    op_feed = vel_r;
        2'd1:    op_feed = disp_r;
        2'd2:    op_feed = force_r;
        default: op_feed = mers_pkg::Q_ONE;
      endcase
    end else begin
      op_first = (op_r == OP_OUT0);
      op_last  = (op_r == OP_BIAS);
      if (op_r == OP_BIAS) begin
        op_feed = mers_pkg::Q_ONE;
      end else begin
        op_feed = 32'(hid_r[hid_off[HID_W-1:0]]);
      end
    end
  end

  // Shared multiplier: weights during the network pass, then the Euler products.
  always_comb begin
    priority case (state_r)
      ST_EMUL_O: begin
        mul_a = 32'(o_r);
        mul_b = dt_r;
      end
      ST_EMUL_V: begin
        mul_a = vel_r;
        mul_b = dt_r;
      end
      default: begin
        mul_a = $signed(rd_data);
        mul_b = feed_b_r;
      end
    endcase
  end

  assign prod_en = tag_b_r.valid || (state_r == ST_EMUL_O) || (state_r == ST_EMUL_V);
  assign prod_sh = prod_r >>> 16;
  assign term48  = $signed(prod_sh[47:0]);

  // Accumulate: the first term of a neuron restarts the sum.
  assign acc_nxt = tag_c_r.first ? AW'(term48) : (acc_r + AW'(term48));

  // Tanh index: the sum is mapped from [-4, 4) onto the table.
  assign t_off    = acc_r[18:0] + 19'd262144;
  assign t_scaled = SCALE_W'(t_off) * SCALE_W'(TANH_TABLE_DEPTH);

  always_comb begin
    if (acc_r < SPAN_NEG) begin
      tsel_nxt = TS_NEG;
    end else if (acc_r >= SPAN_POS) begin
      tsel_nxt = TS_POS;
    end else begin
      tsel_nxt = TS_TABLE;
    end
  end

  always_comb begin
    unique case (tsel_r)
      TS_POS:  tanh_val = TANH_POS1;
      TS_NEG:  tanh_val = TANH_NEG1;
      default: tanh_val = tanh_rom[tidx_r];
    endcase
  end

  // Euler updates and error totals.
  assign vel_nxt  = sat32(49'(vel_r) + 49'(term48));
  assign disp_nxt = sat32(49'(disp_r) + 49'(term48));

  assign diff      = 33'(target_r) - 33'(o_r);
  assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
  assign step_err  = (diff_abs > 33'd2147483647) ? 31'h7fffffff : diff_abs[30:0];
  assign total_sum = {1'b0, err_sum_r} + {1'b0, step_err};
  assign total_nxt = total_sum[31] ? 31'h7fffffff : total_sum[30:0];

  // Sequencer, pipeline valids, architectural state and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= '0;
      gap_r       <= '0;
      hcnt_r      <= '0;
      tag_b_r     <= '0;
      tag_c_r     <= '0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vel_r       <= '0;
      disp_r      <= '0;
      force_r     <= '0;
      err_sum_r   <= '0;
    end else begin
      tag_b_r.valid <= issue_en;
      tag_b_r.first <= op_first;
      tag_b_r.last  <= op_last;
      tag_c_r       <= tag_b_r;
      d_valid_r     <= tag_c_r.valid && tag_c_r.last;
      e_valid_r     <= d_valid_r;

      if (e_valid_r && (hcnt_r != HCNT_OUT)) begin
        hcnt_r <= hcnt_r + 1'b1;
      end

      // A finishing step loads the result register; otherwise a taken result empties it.
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_req_type)
              mers_pkg::REQ_INIT: begin
                vel_r     <= in_init_velocity;
                disp_r    <= in_init_displacement;
                force_r   <= in_init_force;
                err_sum_r <= '0;
              end
              mers_pkg::REQ_STEP: begin
                op_r    <= '0;
                gap_r   <= '0;
                hcnt_r  <= '0;
                state_r <= ST_ISSUE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ISSUE: begin
          if (gap_r != '0) begin
            gap_r <= gap_r - 1'b1;
          end else begin
            if (op_r == OP_LAST_HID) begin
              gap_r <= GAP_LOAD;
            end
            if (op_r == OP_BIAS) begin
              state_r <= ST_DRAIN;
            end else begin
              op_r <= op_r + 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (e_valid_r && (hcnt_r == HCNT_OUT)) begin
            state_r <= ST_EMUL_O;
          end
        end
        ST_EMUL_O: begin
          state_r <= ST_EADD_V;
        end
        ST_EADD_V: begin
          vel_r   <= vel_nxt;
          state_r <= ST_EMUL_V;
        end
        ST_EMUL_V: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            disp_r    <= disp_nxt;
            force_r   <= '0;
            err_sum_r <= total_nxt;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_acc && (in_req_type == mers_pkg::REQ_STEP)) begin
      dt_r     <= in_time_delta;
      target_r <= in_target_value;
    end
    if (issue_en) begin
      feed_b_r <= op_feed;
    end
    if (prod_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (tag_c_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (d_valid_r) begin
      tidx_r <= t_scaled[19 +: TIDX_W];
      tsel_r <= tsel_nxt;
    end
    if (e_valid_r) begin
      if (hcnt_r == HCNT_OUT) begin
        o_r <= tanh_val;
      end else begin
        hid_r[hcnt_r[HID_W-1:0]] <= tanh_val;
      end
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_net_r   <= 18'(o_r);
      out_vel_r   <= vel_r;
      out_disp_r  <= disp_nxt;
      out_err_r   <= step_err;
      out_total_r <= total_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_net_output       = out_net_r;
  assign out_new_velocity     = out_vel_r;
  assign out_new_displacement = out_disp_r;
  assign out_step_error       = out_err_r;
  assign out_error_total      = out_total_r;

endmodule

`default_nettype wire
